/* design/lkd_pkg.sv */
`timescale 1ns / 1ps

package lkd_pkg;

  // sizing
  localparam int LINE_COUNT      = 8;
  localparam int LEVEL_COUNT     = 4;
  localparam int TOP_LEVEL_KEYS  = 3;
  localparam int KEY_SLOTS       = LEVEL_COUNT * LINE_COUNT;
  localparam int LKD_QUEUE_DEPTH = 2;

  typedef logic [4:0] key_t;
  typedef logic [9:0] sample_t;

  // no key pressed
  localparam key_t KEY_NONE = 5'd27;

  // register reset values
  localparam sample_t    LEVEL_ONE_RST      = 10'd830;
  localparam sample_t    LEVEL_TWO_RST      = 10'd512;
  localparam sample_t    LEVEL_THREE_RST    = 10'd326;
  localparam sample_t    LEVEL_FOUR_RST     = 10'd14;
  localparam logic [8:0] TOLERANCE_RST      = 9'd50;
  localparam logic [2:0] OCTAVE_BASE_RST    = 3'd3;
  localparam logic [6:0] PRESS_VELOCITY_RST = 7'd127;
  localparam logic [4:0] MIDI_CHAN_RST      = 5'd1;

  // register indexes on the config port
  typedef enum logic [2:0] {
    REG_LEVEL_ONE,
    REG_LEVEL_TWO,
    REG_LEVEL_THREE,
    REG_LEVEL_FOUR,
    REG_TOLERANCE,
    REG_OCTAVE_BASE,
    REG_PRESS_VELOCITY,
    REG_MIDI_CHAN
  } reg_index_t;

  typedef struct packed {
    sample_t [LEVEL_COUNT-1:0] level;
    logic [8:0]                tolerance;
    logic [2:0]                octave_base;
    logic [6:0]                press_velocity;
    logic [4:0]                midi_chan;
  } cfg_t;

  // one key change, as queued between front and back
  typedef struct packed {
    key_t old_key;
    key_t new_key;
  } note_cmd_t;

  typedef struct packed {
    logic      valid;
    note_cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* design/lkd_ifs.sv */
`timescale 1ns / 1ps

// scan of all ladder lines
interface scan_if;
  logic       valid;
  logic       ready;
  logic [9:0] sample_zero;
  logic [9:0] sample_one;
  logic [9:0] sample_two;
  logic [9:0] sample_three;
  logic [9:0] sample_four;
  logic [9:0] sample_five;
  logic [9:0] sample_six;
  logic [9:0] sample_seven;

  modport source (
    output valid, sample_zero, sample_one, sample_two, sample_three,
           sample_four, sample_five, sample_six, sample_seven,
    input  ready
  );
  modport sink (
    input  valid, sample_zero, sample_one, sample_two, sample_three,
           sample_four, sample_five, sample_six, sample_seven,
    output ready
  );
endinterface

// note event
interface event_if;
  logic       valid;
  logic       ready;
  logic       is_note_on;
  logic [6:0] note_number;
  logic [6:0] event_velocity;
  logic [4:0] event_channel;
  logic       last_event;

  modport source (
    output valid, is_note_on, note_number, event_velocity, event_channel, last_event,
    input  ready
  );
  modport sink (
    input  valid, is_note_on, note_number, event_velocity, event_channel, last_event,
    output ready
  );
endinterface

/* design/ladder_key_decode_note_events_core.sv */
`timescale 1ns / 1ps

// channel   dir  handshake        payload
// scan      in   valid / ready    sample_zero .. sample_seven, 10 bit each
// notes     out  valid / ready    is_note_on, note_number, event_velocity,
//                                 event_channel, last_event
// apb       in   psel / penable   paddr[4:0], pwdata, prdata (32 bit)
//
// a scan is taken whenever the change queue has room; a scan that leaves
// the key unchanged pushes nothing into the queue
// the back end sends one event per cycle from its output register while
// notes.ready is high; a change from one key to another gives two events
// rst is synchronous, active high: registers return to defaults, no key held
// a stalled notes channel fills the queue, then scan.ready drops

module ladder_key_decode_note_events_core
  import lkd_pkg::*;
#(
  parameter int QUEUE_DEPTH = LKD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  scan_if.sink        scan,
  event_if.source     notes
);

  cfg_t       cfg;
  reg_index_t reg_idx;
  logic       cfg_write;
  q_push_t    q_push;
  q_status_t  q_stat;
  note_cmd_t  q_head;
  logic       q_pop;

  // register file
  assign pready    = 1'b1;
  assign reg_idx   = reg_index_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level[0]       <= LEVEL_ONE_RST;
      cfg.level[1]       <= LEVEL_TWO_RST;
      cfg.level[2]       <= LEVEL_THREE_RST;
      cfg.level[3]       <= LEVEL_FOUR_RST;
      cfg.tolerance      <= TOLERANCE_RST;
      cfg.octave_base    <= OCTAVE_BASE_RST;
      cfg.press_velocity <= PRESS_VELOCITY_RST;
      cfg.midi_chan      <= MIDI_CHAN_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_LEVEL_ONE:      cfg.level[0]       <= pwdata[9:0];
        REG_LEVEL_TWO:      cfg.level[1]       <= pwdata[9:0];
        REG_LEVEL_THREE:    cfg.level[2]       <= pwdata[9:0];
        REG_LEVEL_FOUR:     cfg.level[3]       <= pwdata[9:0];
        REG_TOLERANCE:      cfg.tolerance      <= pwdata[8:0];
        REG_OCTAVE_BASE:    cfg.octave_base    <= pwdata[2:0];
        REG_PRESS_VELOCITY: cfg.press_velocity <= pwdata[6:0];
        REG_MIDI_CHAN:      cfg.midi_chan      <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_LEVEL_ONE:      prdata = 32'(cfg.level[0]);
      REG_LEVEL_TWO:      prdata = 32'(cfg.level[1]);
      REG_LEVEL_THREE:    prdata = 32'(cfg.level[2]);
      REG_LEVEL_FOUR:     prdata = 32'(cfg.level[3]);
      REG_TOLERANCE:      prdata = 32'(cfg.tolerance);
      REG_OCTAVE_BASE:    prdata = 32'(cfg.octave_base);
      REG_PRESS_VELOCITY: prdata = 32'(cfg.press_velocity);
      REG_MIDI_CHAN:      prdata = 32'(cfg.midi_chan);
      default:            prdata = '0;
    endcase
  end

  // decode scans into key changes
  lkd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan),
    .cfg    (cfg),
    .q_full (q_stat.full),
    .q_push (q_push)
  );

  // key change queue
  lkd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .pop    (q_pop),
    .head   (q_head),
    .status (q_stat)
  );

  // turn key changes into note events
  lkd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (q_head),
    .q_empty (q_stat.empty),
    .pop     (q_pop),
    .notes   (notes)
  );

  // queued changes always move between two different keys
  a_change_differs : assert property (@(posedge clk) disable iff (rst)
    q_push.valid |-> (q_push.cmd.old_key != q_push.cmd.new_key))
    else $error("queued key change without a change");

  // nothing is pushed into a full queue
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    q_push.valid |-> !q_stat.full)
    else $error("push into full change queue");

  // a note-on always closes the scan
  a_on_is_last : assert property (@(posedge clk) disable iff (rst)
    (notes.valid && notes.is_note_on) |-> notes.last_event)
    else $error("note-on not marked as last event");

  // a note-off carries zero velocity
  a_off_velocity : assert property (@(posedge clk) disable iff (rst)
    (notes.valid && !notes.is_note_on) |-> (notes.event_velocity == 7'd0))
    else $error("note-off with nonzero velocity");

endmodule

/* design/lkd_front.sv */
`timescale 1ns / 1ps

module lkd_front
  import lkd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  scan_if.sink      scan,
  input  cfg_t      cfg,
  input  logic      q_full,
  output q_push_t   q_push
);

  sample_t                samples [LINE_COUNT];
  logic [KEY_SLOTS-1:0]   hit;
  key_t                   found;
  key_t                   held_key;
  logic                   accept;

  // signed inclusive window, bounds not wrapped
  function automatic logic in_window(sample_t s, sample_t lvl, logic [8:0] tol);
    logic signed [11:0] sv;
    logic signed [11:0] lo;
    logic signed [11:0] hi;
    sv = $signed({2'b00, s});
    lo = $signed({2'b00, lvl}) - $signed({3'b000, tol});
    hi = $signed({2'b00, lvl}) + $signed({3'b000, tol});
    return (sv >= lo) && (sv <= hi);
  endfunction

  assign samples[0] = scan.sample_zero;
  assign samples[1] = scan.sample_one;
  assign samples[2] = scan.sample_two;
  assign samples[3] = scan.sample_three;
  assign samples[4] = scan.sample_four;
  assign samples[5] = scan.sample_five;
  assign samples[6] = scan.sample_six;
  assign samples[7] = scan.sample_seven;

  // window match per key slot; top level has only its first lines as keys
  for (genvar lv = 0; lv < LEVEL_COUNT; lv++) begin : g_level
    for (genvar ln = 0; ln < LINE_COUNT; ln++) begin : g_line
      if (lv == LEVEL_COUNT - 1 && ln >= TOP_LEVEL_KEYS) begin : g_unused
        assign hit[lv*LINE_COUNT+ln] = 1'b0;
      end else begin : g_key
        assign hit[lv*LINE_COUNT+ln] = in_window(samples[ln], cfg.level[lv], cfg.tolerance);
      end
    end
  end

  // highest matching key wins
  always_comb begin
    found = KEY_NONE;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (hit[i]) found = key_t'(i);
    end
  end

  // accept while the queue has room, queue only key changes
  assign scan.ready    = !q_full;
  assign accept        = scan.valid && scan.ready;
  assign q_push.valid  = accept && (found != held_key);
  assign q_push.cmd    = '{old_key: held_key, new_key: found};

  // held key
  always_ff @(posedge clk) begin
    if (rst) begin
      held_key <= KEY_NONE;
    end else if (accept) begin
      held_key <= found;
    end
  end

endmodule

/* design/lkd_queue.sv */
`timescale 1ns / 1ps

module lkd_queue
  import lkd_pkg::*;
#(
  parameter int DEPTH = LKD_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  q_push_t   push,
  input  logic      pop,
  output note_cmd_t head,
  output q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  note_cmd_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push.valid && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/lkd_back.sv */
`timescale 1ns / 1ps

module lkd_back
  import lkd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  note_cmd_t head,
  input  logic      q_empty,
  output logic      pop,
  event_if.source   notes
);

  logic       off_done;
  logic       off_done_next;
  logic       load;
  logic       emit_off;
  logic       ev_on;
  key_t       ev_key;
  logic       ev_last;
  logic [6:0] note_sum;

  // a change is queued and the output register is free or being emptied
  assign load = !q_empty && (!notes.valid || notes.ready);

  // note-off for the old key first, if any, then note-on for the new one, if any
  always_comb begin
    emit_off      = !off_done && (head.old_key != KEY_NONE);
    ev_on         = !emit_off;
    ev_key        = emit_off ? head.old_key : head.new_key;
    ev_last       = emit_off ? (head.new_key == KEY_NONE) : 1'b1;
    pop           = load && ev_last;
    off_done_next = off_done;
    if (load) off_done_next = !ev_last;
  end

  // octave * 12 + key, kept to seven bits
  assign note_sum = 7'({ cfg.octave_base, 3'b000 }) + 7'({ cfg.octave_base, 2'b00 })
                  + 7'(ev_key);

  // phase within one queued change
  always_ff @(posedge clk) begin
    if (rst) begin
      off_done <= 1'b0;
    end else begin
      off_done <= off_done_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      notes.valid <= 1'b0;
    end else if (load) begin
      notes.valid <= 1'b1;
    end else if (notes.ready) begin
      notes.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      notes.is_note_on     <= ev_on;
      notes.note_number    <= note_sum;
      notes.event_velocity <= ev_on ? cfg.press_velocity : 7'd0;
      notes.event_channel  <= cfg.midi_chan;
      notes.last_event     <= ev_last;
    end
  end

endmodule
